>>> rtl/fca_pkg.sv
// fca_pkg: shared types and action codes for the fixed-point complex ALU
// no dependencies; used by the channel interfaces and every rtl module

package fca_pkg;

   localparam int WORD_WIDTH = 32;

   typedef logic signed [WORD_WIDTH-1:0] word_type;

   typedef enum logic [2:0] {
      ACT_RADD = 3'd0,
      ACT_RSUB = 3'd1,
      ACT_RMUL = 3'd2,
      ACT_CADD = 3'd3,
      ACT_CSUB = 3'd4,
      ACT_CMUL = 3'd5
   } action_type;

   typedef logic [2:0] action_code_type;

endpackage

>>> rtl/fca_if.sv
// fca_req_if and fca_rsp_if: valid/ready channels for requests and results
// depends on fca_pkg for the word and action types

interface fca_req_if;
   logic                     valid;
   logic                     ready;
   fca_pkg::action_code_type action;
   fca_pkg::word_type        a_real;
   fca_pkg::word_type        a_imag;
   fca_pkg::word_type        b_real;
   fca_pkg::word_type        b_imag;

   modport source (output valid, action, a_real, a_imag, b_real, b_imag, input ready);
   modport sink   (input valid, action, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface fca_rsp_if;
   logic              valid;
   logic              ready;
   fca_pkg::word_type result_real;
   fca_pkg::word_type result_imag;
   logic              overflow;

   modport source (output valid, result_real, result_imag, overflow, input ready);
   modport sink   (input valid, result_real, result_imag, overflow, output ready);
endinterface

>>> rtl/fca_mul4.sv
// fca_mul4: four registered Q-format products for the complex multiply
// depends on fca_pkg; each product is shifted right by FRAC_BITS and wrapped

module fca_mul4 #(
   parameter int FRAC_BITS = 10
) (
   input  logic              clock,
   input  logic              enable,
   input  fca_pkg::word_type a_real,
   input  fca_pkg::word_type a_imag,
   input  fca_pkg::word_type b_real,
   input  fca_pkg::word_type b_imag,
   output fca_pkg::word_type p_rr,
   output fca_pkg::word_type p_ii,
   output fca_pkg::word_type p_ri,
   output fca_pkg::word_type p_ir
);
   import fca_pkg::*;

   logic signed [2*WORD_WIDTH-1:0] full_rr, full_ii, full_ri, full_ir;
   word_type p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;

   assign full_rr = a_real * b_real;
   assign full_ii = a_imag * b_imag;
   assign full_ri = a_real * b_imag;
   assign full_ir = a_imag * b_real;

   // arithmetic shift then wrap is just a slice of the full product
   always_ff @(posedge clock) begin
      if (enable) begin
         p_rr_ff <= full_rr[FRAC_BITS +: WORD_WIDTH];
         p_ii_ff <= full_ii[FRAC_BITS +: WORD_WIDTH];
         p_ri_ff <= full_ri[FRAC_BITS +: WORD_WIDTH];
         p_ir_ff <= full_ir[FRAC_BITS +: WORD_WIDTH];
      end
   end

   assign p_rr = p_rr_ff;
   assign p_ii = p_ii_ff;
   assign p_ri = p_ri_ff;
   assign p_ir = p_ir_ff;

endmodule

>>> rtl/fixed_point_complex_alu.sv
// fixed_point_complex_alu: Q-format real/complex add, subtract and multiply
// depends on fca_pkg, fca_req_if/fca_rsp_if and fca_mul4
//
//   channel   dir  handshake          payload
//   req_chan  in   valid/ready        action, a_real, a_imag, b_real, b_imag
//   rsp_chan  out  valid/ready        result_real, result_imag, overflow
//
// three register stages: request register, product register, result register;
// one request is taken every cycle while the result side is not stalled
// the four multipliers set the product stage; the add/overflow check sets the last
// a stalled result holds the whole pipeline; req_chan.ready drops only then
// synchronous active-high reset clears the stage valid flags only

module fixed_point_complex_alu #(
   parameter int FRAC_BITS = 10
) (
   input logic   clock,
   input logic   reset,
   fca_req_if.sink   req_chan,
   fca_rsp_if.source rsp_chan
);
   import fca_pkg::*;

   logic advance;

   // request stage
   logic            s1_valid_ff, s1_valid_in;
   action_code_type s1_action_ff;
   word_type        s1_ar_ff, s1_ai_ff, s1_br_ff, s1_bi_ff;

   // product stage
   logic            s2_valid_ff;
   action_code_type s2_action_ff;
   word_type        s2_ar_ff, s2_ai_ff, s2_br_ff, s2_bi_ff;
   word_type        p_rr, p_ii, p_ri, p_ir;

   // result stage
   logic     rsp_valid_ff;
   word_type rsp_real_ff, rsp_real_in;
   word_type rsp_imag_ff, rsp_imag_in;
   logic     rsp_ovf_ff, rsp_ovf_in;

   logic                  cmul;
   word_type              x_r, y_r, x_i, y_i;
   logic                  neg_r, neg_i;
   logic [WORD_WIDTH:0]   sum_r, sum_i;
   logic                  ovf_r, ovf_i;

   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = advance;
   assign s1_valid_in    = req_chan.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_chan.valid) begin
         s1_action_ff <= req_chan.action;
         s1_ar_ff     <= req_chan.a_real;
         s1_ai_ff     <= req_chan.a_imag;
         s1_br_ff     <= req_chan.b_real;
         s1_bi_ff     <= req_chan.b_imag;
      end
      if (advance && s1_valid_ff) begin
         s2_action_ff <= s1_action_ff;
         s2_ar_ff     <= s1_ar_ff;
         s2_ai_ff     <= s1_ai_ff;
         s2_br_ff     <= s1_br_ff;
         s2_bi_ff     <= s1_bi_ff;
      end
      if (advance && s2_valid_ff) begin
         rsp_real_ff <= rsp_real_in;
         rsp_imag_ff <= rsp_imag_in;
         rsp_ovf_ff  <= rsp_ovf_in;
      end
   end

   fca_mul4 #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mul4 (
      .clock  (clock),
      .enable (advance && s1_valid_ff),
      .a_real (s1_ar_ff),
      .a_imag (s1_ai_ff),
      .b_real (s1_br_ff),
      .b_imag (s1_bi_ff),
      .p_rr   (p_rr),
      .p_ii   (p_ii),
      .p_ri   (p_ri),
      .p_ir   (p_ir)
   );

   // complex multiply feeds products into the same add/subtract pair
   assign cmul  = (s2_action_ff == ACT_CMUL);
   assign x_r   = cmul ? p_rr : s2_ar_ff;
   assign y_r   = cmul ? p_ii : s2_br_ff;
   assign x_i   = cmul ? p_ri : s2_ai_ff;
   assign y_i   = cmul ? p_ir : s2_bi_ff;
   assign neg_r = cmul || (s2_action_ff == ACT_RSUB) || (s2_action_ff == ACT_CSUB);
   assign neg_i = (s2_action_ff == ACT_CSUB);

   // 33-bit exact result; overflow when the top two bits differ
   assign sum_r = neg_r ? ({x_r[WORD_WIDTH-1], x_r} - {y_r[WORD_WIDTH-1], y_r})
                        : ({x_r[WORD_WIDTH-1], x_r} + {y_r[WORD_WIDTH-1], y_r});
   assign sum_i = neg_i ? ({x_i[WORD_WIDTH-1], x_i} - {y_i[WORD_WIDTH-1], y_i})
                        : ({x_i[WORD_WIDTH-1], x_i} + {y_i[WORD_WIDTH-1], y_i});
   assign ovf_r = sum_r[WORD_WIDTH] ^ sum_r[WORD_WIDTH-1];
   assign ovf_i = sum_i[WORD_WIDTH] ^ sum_i[WORD_WIDTH-1];

   always_comb begin
      rsp_real_in = '0;
      rsp_imag_in = '0;
      rsp_ovf_in  = 1'b0;
      unique case (s2_action_ff)
         ACT_RADD, ACT_RSUB: begin
            rsp_real_in = word_type'(sum_r[WORD_WIDTH-1:0]);
            rsp_ovf_in  = ovf_r;
         end
         ACT_RMUL: begin
            rsp_real_in = p_rr;
         end
         ACT_CADD, ACT_CSUB, ACT_CMUL: begin
            rsp_real_in = word_type'(sum_r[WORD_WIDTH-1:0]);
            rsp_imag_in = word_type'(sum_i[WORD_WIDTH-1:0]);
            rsp_ovf_in  = ovf_r || ovf_i;
         end
         default: begin
            rsp_real_in = '0;
            rsp_imag_in = '0;
            rsp_ovf_in  = 1'b0;
         end
      endcase
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.result_real = rsp_real_ff;
   assign rsp_chan.result_imag = rsp_imag_ff;
   assign rsp_chan.overflow    = rsp_ovf_ff;

endmodule

>>> sim/testbench.sv
// testbench for fixed_point_complex_alu: directed and random requests, with an
// independent Q-format predictor and an in-order result scoreboard
// depends on fca_pkg, fca_req_if/fca_rsp_if and the fixed_point_complex_alu rtl

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import fca_pkg::*;

   localparam int FRAC_BITS     = 10;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 300;
   localparam int CYCLE_LIMIT   = 400000;

   localparam action_code_type ACT_SPARE_6 = 3'd6;
   localparam action_code_type ACT_SPARE_7 = 3'd7;

   localparam word_type WORD_MAX = 32'sh7fff_ffff;
   localparam word_type WORD_MIN = 32'sh8000_0000;
   localparam word_type Q_ONE    = 32'sd1024;
   localparam word_type BIG_Q    = 32'sh0010_0000;

   typedef struct packed {
      action_code_type action;
      word_type        a_real;
      word_type        a_imag;
      word_type        b_real;
      word_type        b_imag;
   } alu_request_type;

   typedef struct packed {
      word_type result_real;
      word_type result_imag;
      logic     overflow;
   } alu_result_type;

   logic clock = 1'b0;
   logic reset;

   fca_req_if req_chan ();
   fca_rsp_if rsp_chan ();

   fixed_point_complex_alu #(
      .FRAC_BITS(FRAC_BITS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   alu_result_type expected_results[$];
   int             error_count = 0;
   int             cycle_count = 0;
   int             idle_pct    = 0;
   int             stall_pct   = 0;
   int             hold_token  = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // exact add or subtract of two int32 values; sets flag when outside int32
   function automatic longint add_checked(input longint x, input longint y,
                                          input bit subtract, inout logic flag);
      longint sum;
      sum = subtract ? x - y : x + y;
      if (sum > longint'(WORD_MAX) || sum < longint'(WORD_MIN))
         flag = 1'b1;
      return longint'(word_type'(sum));
   endfunction

   // full product, arithmetic shift, keep the low word
   function automatic longint q_multiply(input longint x, input longint y);
      longint     product;
      logic [63:0] shifted;
      product = x * y;
      shifted = product >>> FRAC_BITS;
      return longint'(word_type'(shifted[31:0]));
   endfunction

   function automatic alu_result_type predict_alu_result(input alu_request_type req);
      alu_result_type res;
      longint ar, ai, br, bi, rr, ri;
      logic   ovf;
      ar  = longint'(req.a_real);
      ai  = longint'(req.a_imag);
      br  = longint'(req.b_real);
      bi  = longint'(req.b_imag);
      rr  = 0;
      ri  = 0;
      ovf = 1'b0;
      case (req.action)
         ACT_RADD: rr = add_checked(ar, br, 1'b0, ovf);
         ACT_RSUB: rr = add_checked(ar, br, 1'b1, ovf);
         ACT_RMUL: rr = q_multiply(ar, br);
         ACT_CADD: begin
            rr = add_checked(ar, br, 1'b0, ovf);
            ri = add_checked(ai, bi, 1'b0, ovf);
         end
         ACT_CSUB: begin
            rr = add_checked(ar, br, 1'b1, ovf);
            ri = add_checked(ai, bi, 1'b1, ovf);
         end
         ACT_CMUL: begin
            rr = add_checked(q_multiply(ar, br), q_multiply(ai, bi), 1'b1, ovf);
            ri = add_checked(q_multiply(ar, bi), q_multiply(ai, br), 1'b0, ovf);
         end
         default: ;
      endcase
      res.result_real = word_type'(rr);
      res.result_imag = word_type'(ri);
      res.overflow    = ovf;
      return res;
   endfunction

   task automatic send_request(input action_code_type action, input word_type ar,
                               input word_type ai, input word_type br, input word_type bi);
      alu_request_type req;
      req = '{action, ar, ai, br, bi};
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid  = 1'b1;
      req_chan.action = action;
      req_chan.a_real = ar;
      req_chan.a_imag = ai;
      req_chan.b_real = br;
      req_chan.b_imag = bi;
      do @(posedge clock); while (!req_chan.ready);
      expected_results.push_back(predict_alu_result(req));
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic word_type random_operand();
      int v;
      case ($urandom_range(7))
         0, 1, 2: v = int'($urandom());
         3:       v = int'($urandom_range(8192)) - 4096;
         4:       v = int'(WORD_MAX) - int'($urandom_range(255));
         5:       v = int'(WORD_MIN) + int'($urandom_range(255));
         6:       v = int'($urandom()) >>> $urandom_range(31);
         default: begin
            v = int'($urandom_range(1, 65535)) * int'(Q_ONE);
            if ($urandom_range(1))
               v = -v;
         end
      endcase
      return word_type'(v);
   endfunction

   function automatic action_code_type random_action();
      if ($urandom_range(99) < 4)
         return $urandom_range(1) ? ACT_SPARE_7 : ACT_SPARE_6;
      return action_code_type'($urandom_range(5));
   endfunction

   task automatic test_edge_operands();
      idle_pct  = 0;
      stall_pct = 0;
      // add and subtract at and just past the int32 limits
      send_request(ACT_RADD, WORD_MAX, 32'sd0, 32'sd1, 32'sd0);
      send_request(ACT_RADD, WORD_MIN, 32'sd0, -32'sd1, 32'sd0);
      send_request(ACT_RSUB, WORD_MIN, 32'sd0, 32'sd1, 32'sd0);
      send_request(ACT_RSUB, 32'sd0, 32'sd0, WORD_MIN, 32'sd0);
      send_request(ACT_RSUB, -32'sd1, 32'sd0, WORD_MAX, 32'sd0);
      send_request(ACT_RADD, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
      // imaginary inputs must not leak into real actions
      send_request(ACT_RADD, Q_ONE, WORD_MAX, Q_ONE, WORD_MAX);
      send_request(ACT_RSUB, Q_ONE, -32'sd1, 32'sd5, WORD_MIN);
      // real multiply: exact, rounding toward minus infinity, wrap without flag
      send_request(ACT_RMUL, 32'sd1536, 32'sd7, 32'sd2048, 32'sd9);
      send_request(ACT_RMUL, -32'sd1, 32'sd0, 32'sd1, 32'sd0);
      send_request(ACT_RMUL, WORD_MAX, 32'sd0, WORD_MAX, 32'sd0);
      send_request(ACT_RMUL, WORD_MIN, 32'sd0, WORD_MIN, 32'sd0);
      send_request(ACT_RMUL, WORD_MIN, -32'sd1, WORD_MAX, -32'sd1);
      // complex add and subtract, overflow on one part only
      send_request(ACT_CADD, 32'sd3, WORD_MAX, 32'sd4, 32'sd1);
      send_request(ACT_CSUB, WORD_MIN, 32'sd2, 32'sd1, 32'sd1);
      send_request(ACT_CSUB, 32'sd0, 32'sd0, 32'sd0, WORD_MIN);
      // complex multiply: plain, real part overflow, imaginary part overflow, full-scale, zero
      send_request(ACT_CMUL, Q_ONE, 32'sd2048, 32'sd3072, 32'sd4096);
      send_request(ACT_CMUL, BIG_Q, BIG_Q, BIG_Q, -BIG_Q);
      send_request(ACT_CMUL, BIG_Q, BIG_Q, BIG_Q, BIG_Q);
      send_request(ACT_CMUL, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
      send_request(ACT_CMUL, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
      send_request(ACT_CMUL, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
      // unused action codes give an all-zero result
      send_request(ACT_SPARE_6, WORD_MAX, WORD_MAX, WORD_MAX, 32'sd1);
      send_request(ACT_SPARE_7, -32'sd1, -32'sd1, -32'sd1, -32'sd1);
      wait_for_results();
   endtask

   task automatic test_random_stream(input int count, input int sender_idle,
                                     input int receiver_stall);
      idle_pct  = sender_idle;
      stall_pct = receiver_stall;
      repeat (count)
         send_request(random_action(), random_operand(), random_operand(),
                      random_operand(), random_operand());
      wait_for_results();
   endtask

   // result side held off while requests keep coming, so the pipeline fills
   task automatic test_result_holdoff();
      idle_pct   = 0;
      stall_pct  = 0;
      hold_token = hold_token + 1;
      repeat (40)
         send_request(random_action(), random_operand(), random_operand(),
                      random_operand(), random_operand());
      wait_for_results();
   endtask

   // result ready, driven at the falling edge
   initial begin
      int hold_left;
      int hold_seen;
      hold_left     = 0;
      hold_seen     = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_chan.ready = 1'b0;
            hold_left--;
         end else begin
            rsp_chan.ready = ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      alu_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_results.size() == 0) begin
            $error("result with no request outstanding: real %0d imag %0d overflow %0b",
                   rsp_chan.result_real, rsp_chan.result_imag, rsp_chan.overflow);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_chan.result_real !== want.result_real) begin
               $error("result_real expected %0d got %0d", want.result_real,
                      rsp_chan.result_real);
               error_count++;
            end
            if (rsp_chan.result_imag !== want.result_imag) begin
               $error("result_imag expected %0d got %0d", want.result_imag,
                      rsp_chan.result_imag);
               error_count++;
            end
            if (rsp_chan.overflow !== want.overflow) begin
               $error("overflow expected %0b got %0b", want.overflow, rsp_chan.overflow);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("fixed_point_complex_alu verification failed");
         $finish;
      end
   end

   initial begin
      int leftover;
      reset           = 1'b1;
      req_chan.valid  = 1'b0;
      req_chan.action = ACT_RADD;
      req_chan.a_real = '0;
      req_chan.a_imag = '0;
      req_chan.b_real = '0;
      req_chan.b_imag = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_edge_operands();
      test_random_stream(390, 0, 0);
      test_random_stream(390, 73, 0);
      test_random_stream(390, 0, 73);
      test_random_stream(390, 17, 17);
      test_result_holdoff();

      leftover = expected_results.size();
      if (leftover != 0)
         $error("%0d results never arrived", leftover);
      if (error_count == 0 && leftover == 0)
         $display("fixed_point_complex_alu verification clean");
      else
         $display("fixed_point_complex_alu verification failed");
      $finish;
   end

endmodule
